// ===== sv/lrs_pkg.sv =====
// Package: widths, types, state codes and helpers for the line rasterizer stepper.
`timescale 1ns / 1ps

package lrs_pkg;

   localparam int CB     = 12;            // coordinate bits
   localparam int FB     = 16;            // fraction bits of Q1.FB results
   localparam int Q_W    = FB + 1;        // ratio result width, 1.0 representable
   localparam int V_W    = 2 * FB + 1;    // quotient width before the square root
   localparam int ERR_W  = CB + 3;        // walker error term
   localparam int EXT_W  = ERR_W + 2;     // signed working width for error math
   localparam int MAG_W  = CB + 3;        // squarer operand width
   localparam int NUM_W  = 2 * MAG_W;     // squared numerator width
   localparam int L2_W   = 2 * CB + 1;    // squared line length width
   localparam int CNT_W  = $clog2(V_W);   // ratio unit step counter
   localparam int CAND_N = 3;             // fragments one step can produce
   localparam int IDX_W  = 2;             // candidate index, one code past the last

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             plain;    // coverage fixed at zero
      logic             strict;   // neighbour: drop when distance reaches length
      logic [CB-1:0]    x;
      logic [CB-1:0]    y;
      logic [MAG_W-1:0] mag;      // distance magnitude for coverage
      logic [CB-1:0]    fdx;      // walker offset from origin for the fraction
      logic [CB-1:0]    fdy;
   } cand_type;

   typedef struct packed {
      logic [CB-1:0]  x;
      logic [CB-1:0]  y;
      logic [Q_W-1:0] cov;
      logic [Q_W-1:0] frac;
   } frag_type;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_L2      = 9'b000000010,
      ST_NEXT    = 9'b000000100,
      ST_SQ_COV  = 9'b000001000,
      ST_RUN_COV = 9'b000010000,
      ST_SQ_FX   = 9'b000100000,
      ST_SQ_FY   = 9'b001000000,
      ST_RUN_FR  = 9'b010000000,
      ST_SEND    = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_DIV  = 3'b010,
      R_SQRT = 3'b100
   } ratio_state_type;

   function automatic logic [CB-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
      absdiff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== sv/lrs_channels.sv =====
// Channel interfaces: step/start requests, fragment responses, control register write.
`timescale 1ns / 1ps

interface lrs_req_if;
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [lrs_pkg::CB-1:0] start_x;
   logic [lrs_pkg::CB-1:0] start_y;
   logic [lrs_pkg::CB-1:0] end_x;
   logic [lrs_pkg::CB-1:0] end_y;
   modport source(output valid, operation, start_x, start_y, end_x, end_y, input ready);
   modport sink(input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrs_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [lrs_pkg::CB-1:0]  pixel_x;
   logic [lrs_pkg::CB-1:0]  pixel_y;
   logic [lrs_pkg::Q_W-1:0] coverage;
   logic [lrs_pkg::Q_W-1:0] along_fraction;
   logic                    line_done;
   logic                    last;
   modport source(output valid, pixel_x, pixel_y, coverage, along_fraction, line_done, last,
                  input ready);
   modport sink(input valid, pixel_x, pixel_y, coverage, along_fraction, line_done, last,
                output ready);
endinterface

interface lrs_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

// ===== sv/line_rasterizer_stepper.sv =====
// Top level: all-octant line walker with optional anti-aliased neighbour fragments.
`timescale 1ns / 1ps

// A start transfer loads two endpoints and builds the squared length on the
// shared squarer (dx^2 in ST_IDLE, dy^2 added in ST_L2); it yields no
// response. A step transfer runs one walker iteration and yields 0 to 3
// fragment transfers, the last one flagged by last, all flagged by line_done
// when the step hit the end point. One item at a time: req ready is high
// only while the block is idle. Each surviving fragment costs one ratio run
// for along_fraction and, in smooth mode, one more for coverage; a ratio run
// is a restoring division then a bit-serial square root in the shared
// divide/square-root unit, with squaring states ahead of the fraction run
// and a sequencing state per candidate. Fragments are then sent while rsp is
// ready. Steps with no line loaded are taken and dropped with no response.
// smooth_enable may be written at any time the block is idle and applies
// from the next step.

module line_rasterizer_stepper (
   input  logic      clock,
   input  logic      reset,
   lrs_req_if.sink   req_bus,
   lrs_rsp_if.source rsp_bus,
   lrs_csr_if.sink   csr_bus
);

   localparam int CB    = lrs_pkg::CB;
   localparam int EXT_W = lrs_pkg::EXT_W;

   lrs_pkg::state_type state_ff, state_in;
   logic                      smooth_ff, smooth_in;
   logic                      active_ff, active_in;
   logic [CB-1:0]             walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic [CB-1:0]             target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [CB-1:0]             origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [CB-1:0]             abs_dx_ff, abs_dx_in, abs_dy_ff, abs_dy_in;
   logic [1:0]                signs_ff, signs_in;   // bit0 x goes down, bit1 y goes down
   logic [lrs_pkg::ERR_W-1:0] err_ff, err_in;
   logic [lrs_pkg::L2_W-1:0]  len_sq_ff, len_sq_in;
   lrs_pkg::cand_type         cand_ff [lrs_pkg::CAND_N];
   lrs_pkg::cand_type         cand_in [lrs_pkg::CAND_N];
   lrs_pkg::frag_type         res_ff  [lrs_pkg::CAND_N];
   lrs_pkg::frag_type         res_in  [lrs_pkg::CAND_N];
   logic [lrs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [lrs_pkg::IDX_W-1:0] res_n_ff, res_n_in;
   logic [lrs_pkg::IDX_W-1:0] send_ff, send_in;
   logic [lrs_pkg::Q_W-1:0]   cov_ff, cov_in;
   logic [lrs_pkg::NUM_W-1:0] fx2_ff, fx2_in;
   logic                      done_ff, done_in;

   // handshakes
   logic req_fire, rsp_fire, csr_fire;
   assign req_bus.ready = (state_ff == lrs_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   // shared squarer
   logic [lrs_pkg::MAG_W-1:0] sq_op;
   logic [lrs_pkg::NUM_W-1:0] sq;
   lrs_pkg::cand_type         cur;
   logic [CB-1:0]             req_dx, req_dy;

   assign cur    = cand_ff[idx_ff];
   assign req_dx = lrs_pkg::absdiff(req_bus.start_x, req_bus.end_x);
   assign req_dy = lrs_pkg::absdiff(req_bus.start_y, req_bus.end_y);

   always_comb begin
      unique case (state_ff)
         lrs_pkg::ST_IDLE:   sq_op = lrs_pkg::MAG_W'(req_dx);
         lrs_pkg::ST_L2:     sq_op = lrs_pkg::MAG_W'(abs_dy_ff);
         lrs_pkg::ST_SQ_COV: sq_op = cur.mag;
         lrs_pkg::ST_SQ_FX:  sq_op = lrs_pkg::MAG_W'(cur.fdx);
         lrs_pkg::ST_SQ_FY:  sq_op = lrs_pkg::MAG_W'(cur.fdy);
         default:            sq_op = '0;
      endcase
   end
   assign sq = sq_op * sq_op;

   // ratio unit
   logic                      ratio_start, ratio_done, ratio_ok;
   logic [lrs_pkg::NUM_W-1:0] ratio_num;
   logic [lrs_pkg::Q_W-1:0]   ratio_q;

   assign ratio_num = (state_ff == lrs_pkg::ST_SQ_COV) ? sq : (fx2_ff + sq);

   lrs_ratio_unit u_ratio (
      .clock (clock),
      .reset (reset),
      .start (ratio_start),
      .num   (ratio_num),
      .den   (len_sq_ff),
      .done  (ratio_done),
      .ok    (ratio_ok),
      .q     (ratio_q)
   );

   // walker step math, all from the current line state
   logic signed [EXT_W-1:0] dx_s, dy_s, err_x, d_s, d_abs, e2, m1, m2, err_nxt;
   logic                    at_end, c1, c2;
   logic [CB-1:0]           step_x, step_y, new_x, fdx0, fdy0;

   assign dx_s   = $signed({{(EXT_W-CB){1'b0}}, abs_dx_ff});
   assign dy_s   = $signed({{(EXT_W-CB){1'b0}}, abs_dy_ff});
   assign err_x  = $signed({{(EXT_W-lrs_pkg::ERR_W){err_ff[lrs_pkg::ERR_W-1]}}, err_ff});
   assign d_s    = err_x - dx_s + dy_s;
   assign d_abs  = (d_s < 0) ? -d_s : d_s;
   assign e2     = err_x <<< 1;
   assign m1     = err_x + dy_s;
   assign m2     = dx_s - err_x;
   assign at_end = (walk_x_ff == target_x_ff) && (walk_y_ff == target_y_ff);
   // smooth mode steps against the other axis than the plain rule
   assign c1     = smooth_ff ? (e2 >= -dx_s) : (e2 >= -dy_s);
   assign c2     = smooth_ff ? (e2 <= dy_s) : (e2 <= dx_s);
   assign err_nxt = err_x - (c1 ? dy_s : '0) + (c2 ? dx_s : '0);
   assign step_x = walk_x_ff + (signs_ff[0] ? {CB{1'b1}} : CB'(1));
   assign step_y = walk_y_ff + (signs_ff[1] ? {CB{1'b1}} : CB'(1));
   assign new_x  = c1 ? step_x : walk_x_ff;
   assign fdx0   = lrs_pkg::absdiff(walk_x_ff, origin_x_ff);
   assign fdy0   = lrs_pkg::absdiff(walk_y_ff, origin_y_ff);

   always_comb begin
      state_in    = state_ff;
      smooth_in   = smooth_ff;
      active_in   = active_ff;
      walk_x_in   = walk_x_ff;
      walk_y_in   = walk_y_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      abs_dx_in   = abs_dx_ff;
      abs_dy_in   = abs_dy_ff;
      signs_in    = signs_ff;
      err_in      = err_ff;
      len_sq_in   = len_sq_ff;
      cand_in     = cand_ff;
      res_in      = res_ff;
      idx_in      = idx_ff;
      res_n_in    = res_n_ff;
      send_in     = send_ff;
      cov_in      = cov_ff;
      fx2_in      = fx2_ff;
      done_in     = done_ff;
      ratio_start = 1'b0;

      if (csr_fire) begin
         smooth_in = csr_bus.data;
      end

      unique case (state_ff)
         lrs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == lrs_pkg::OP_START) begin
                  origin_x_in = req_bus.start_x;
                  origin_y_in = req_bus.start_y;
                  walk_x_in   = req_bus.start_x;
                  walk_y_in   = req_bus.start_y;
                  target_x_in = req_bus.end_x;
                  target_y_in = req_bus.end_y;
                  abs_dx_in   = req_dx;
                  abs_dy_in   = req_dy;
                  signs_in    = {!(req_bus.start_y < req_bus.end_y),
                                 !(req_bus.start_x < req_bus.end_x)};
                  err_in      = lrs_pkg::ERR_W'(req_dx) - lrs_pkg::ERR_W'(req_dy);
                  len_sq_in   = sq[lrs_pkg::L2_W-1:0];   // dx^2, dy^2 added next cycle
                  active_in   = 1'b1;
                  state_in    = lrs_pkg::ST_L2;
               end else if (active_ff) begin
                  // main fragment at the current position
                  cand_in[0].valid  = 1'b1;
                  cand_in[0].plain  = !smooth_ff;
                  cand_in[0].strict = 1'b0;
                  cand_in[0].x      = walk_x_ff;
                  cand_in[0].y      = walk_y_ff;
                  cand_in[0].mag    = d_abs[lrs_pkg::MAG_W-1:0];
                  cand_in[0].fdx    = fdx0;
                  cand_in[0].fdy    = fdy0;
                  // neighbour across the minor axis, before the x step
                  cand_in[1].valid  = smooth_ff && !at_end && c1 && (m1 >= 0);
                  cand_in[1].plain  = 1'b0;
                  cand_in[1].strict = 1'b1;
                  cand_in[1].x      = walk_x_ff;
                  cand_in[1].y      = step_y;
                  cand_in[1].mag    = m1[lrs_pkg::MAG_W-1:0];
                  cand_in[1].fdx    = fdx0;
                  cand_in[1].fdy    = fdy0;
                  // neighbour along x; its fraction sees the already stepped x
                  cand_in[2].valid  = smooth_ff && !at_end && c2 && (m2 >= 0);
                  cand_in[2].plain  = 1'b0;
                  cand_in[2].strict = 1'b1;
                  cand_in[2].x      = step_x;
                  cand_in[2].y      = walk_y_ff;
                  cand_in[2].mag    = m2[lrs_pkg::MAG_W-1:0];
                  cand_in[2].fdx    = lrs_pkg::absdiff(new_x, origin_x_ff);
                  cand_in[2].fdy    = fdy0;
                  if (!at_end) begin
                     walk_x_in = new_x;
                     walk_y_in = c2 ? step_y : walk_y_ff;
                     err_in    = err_nxt[lrs_pkg::ERR_W-1:0];
                  end
                  done_in   = at_end;
                  active_in = !at_end;
                  idx_in    = '0;
                  res_n_in  = '0;
                  state_in  = lrs_pkg::ST_NEXT;
               end
            end
         end
         lrs_pkg::ST_L2: begin
            len_sq_in = len_sq_ff + sq[lrs_pkg::L2_W-1:0];
            state_in  = lrs_pkg::ST_IDLE;
         end
         lrs_pkg::ST_NEXT: begin
            if (idx_ff == lrs_pkg::IDX_W'(lrs_pkg::CAND_N)) begin
               send_in  = '0;
               state_in = (res_n_ff == '0) ? lrs_pkg::ST_IDLE : lrs_pkg::ST_SEND;
            end else if (!cur.valid) begin
               idx_in = idx_ff + 1'b1;
            end else if (cur.plain) begin
               cov_in   = '0;
               state_in = lrs_pkg::ST_SQ_FX;
            end else begin
               state_in = lrs_pkg::ST_SQ_COV;
            end
         end
         lrs_pkg::ST_SQ_COV: begin
            if (cur.strict && (sq >= lrs_pkg::NUM_W'(len_sq_ff))) begin
               idx_in   = idx_ff + 1'b1;
               state_in = lrs_pkg::ST_NEXT;
            end else begin
               ratio_start = 1'b1;
               state_in    = lrs_pkg::ST_RUN_COV;
            end
         end
         lrs_pkg::ST_RUN_COV: begin
            if (ratio_done) begin
               if (ratio_ok) begin
                  cov_in   = ratio_q;
                  state_in = lrs_pkg::ST_SQ_FX;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = lrs_pkg::ST_NEXT;
               end
            end
         end
         lrs_pkg::ST_SQ_FX: begin
            fx2_in   = sq;
            state_in = lrs_pkg::ST_SQ_FY;
         end
         lrs_pkg::ST_SQ_FY: begin
            ratio_start = 1'b1;
            state_in    = lrs_pkg::ST_RUN_FR;
         end
         lrs_pkg::ST_RUN_FR: begin
            if (ratio_done) begin
               if (ratio_ok) begin
                  res_in[res_n_ff].x    = cur.x;
                  res_in[res_n_ff].y    = cur.y;
                  res_in[res_n_ff].cov  = cov_ff;
                  res_in[res_n_ff].frac = ratio_q;
                  res_n_in              = res_n_ff + 1'b1;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = lrs_pkg::ST_NEXT;
            end
         end
         lrs_pkg::ST_SEND: begin
            if (rsp_fire) begin
               if (send_ff == res_n_ff - 1'b1) begin
                  state_in = lrs_pkg::ST_IDLE;
               end else begin
                  send_in = send_ff + 1'b1;
               end
            end
         end
         default: state_in = lrs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lrs_pkg::ST_IDLE;
         smooth_ff   <= 1'b0;
         active_ff   <= 1'b0;
         walk_x_ff   <= '0;
         walk_y_ff   <= '0;
         target_x_ff <= '0;
         target_y_ff <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         abs_dx_ff   <= '0;
         abs_dy_ff   <= '0;
         signs_ff    <= '0;
         err_ff      <= '0;
         len_sq_ff   <= '0;
         idx_ff      <= '0;
         res_n_ff    <= '0;
         send_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         smooth_ff   <= smooth_in;
         active_ff   <= active_in;
         walk_x_ff   <= walk_x_in;
         walk_y_ff   <= walk_y_in;
         target_x_ff <= target_x_in;
         target_y_ff <= target_y_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         abs_dx_ff   <= abs_dx_in;
         abs_dy_ff   <= abs_dy_in;
         signs_ff    <= signs_in;
         err_ff      <= err_in;
         len_sq_ff   <= len_sq_in;
         idx_ff      <= idx_in;
         res_n_ff    <= res_n_in;
         send_ff     <= send_in;
      end
      cand_ff <= cand_in;
      res_ff  <= res_in;
      cov_ff  <= cov_in;
      fx2_ff  <= fx2_in;
      done_ff <= done_in;
   end

   // fragment output, straight from the result registers
   lrs_pkg::frag_type out_frag;
   assign out_frag               = res_ff[send_ff];
   assign rsp_bus.valid          = (state_ff == lrs_pkg::ST_SEND);
   assign rsp_bus.pixel_x        = out_frag.x;
   assign rsp_bus.pixel_y        = out_frag.y;
   assign rsp_bus.coverage       = out_frag.cov;
   assign rsp_bus.along_fraction = out_frag.frac;
   assign rsp_bus.line_done      = done_ff;
   assign rsp_bus.last           = (send_ff == res_n_ff - 1'b1);

endmodule

// ===== sv/lrs_ratio_unit.sv =====
// Shared ratio unit: floor(sqrt(num/den) * 2^FB) by restoring division then bit-serial root.
`timescale 1ns / 1ps

module lrs_ratio_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lrs_pkg::NUM_W-1:0]   num,
   input  logic [lrs_pkg::L2_W-1:0]    den,
   output logic                        done,
   output logic                        ok,
   output logic [lrs_pkg::Q_W-1:0]     q
);

   lrs_pkg::ratio_state_type state_ff, state_in;
   logic [lrs_pkg::L2_W-1:0]  r_ff, r_in;
   logic [lrs_pkg::V_W-1:0]   v_ff, v_in;
   logic [lrs_pkg::Q_W-1:0]   q_ff, q_in;
   logic [lrs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic                      ok_ff, ok_in;

   logic [lrs_pkg::L2_W:0]      r2;
   logic                        ge;
   logic [lrs_pkg::L2_W:0]      r2_sub;
   logic [lrs_pkg::Q_W-1:0]     cand;
   logic [2*lrs_pkg::Q_W-1:0]   cand_sq;

   assign r2      = {r_ff, 1'b0};
   assign ge      = r2 >= {1'b0, den};
   assign r2_sub  = r2 - {1'b0, den};
   assign cand    = q_ff | (lrs_pkg::Q_W'(1) << cnt_ff);
   assign cand_sq = cand * cand;

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      v_in     = v_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      ok_in    = ok_ff;
      unique case (state_ff)
         lrs_pkg::R_IDLE: begin
            if (start) begin
               if (den == '0) begin
                  done_in = 1'b1;
                  ok_in   = (num == '0);
                  q_in    = '0;
               end else if (num > lrs_pkg::NUM_W'(den)) begin
                  done_in = 1'b1;
                  ok_in   = 1'b0;
               end else begin
                  v_in     = lrs_pkg::V_W'(num == lrs_pkg::NUM_W'(den));
                  r_in     = (num == lrs_pkg::NUM_W'(den)) ? '0 : num[lrs_pkg::L2_W-1:0];
                  cnt_in   = lrs_pkg::CNT_W'(2 * lrs_pkg::FB - 1);
                  state_in = lrs_pkg::R_DIV;
               end
            end
         end
         lrs_pkg::R_DIV: begin
            r_in = ge ? r2_sub[lrs_pkg::L2_W-1:0] : r2[lrs_pkg::L2_W-1:0];
            v_in = {v_ff[lrs_pkg::V_W-2:0], ge};
            if (cnt_ff == '0) begin
               q_in     = '0;
               cnt_in   = lrs_pkg::CNT_W'(lrs_pkg::FB);
               state_in = lrs_pkg::R_SQRT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         lrs_pkg::R_SQRT: begin
            if (cand_sq <= (2*lrs_pkg::Q_W)'(v_ff)) begin
               q_in = cand;
            end
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               ok_in    = 1'b1;
               state_in = lrs_pkg::R_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = lrs_pkg::R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrs_pkg::R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      r_ff   <= r_in;
      v_ff   <= v_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      ok_ff  <= ok_in;
   end

   assign done = done_ff;
   assign ok   = ok_ff;
   assign q    = q_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the line rasterizer stepper: directed and random lines against a predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int CB  = lrs_pkg::CB;
   localparam int FB  = lrs_pkg::FB;
   localparam int Q_W = lrs_pkg::Q_W;

   // One fragment as the block should send it.
   typedef struct packed {
      logic [CB-1:0]  x;
      logic [CB-1:0]  y;
      logic [Q_W-1:0] cov;
      logic [Q_W-1:0] frac;
      logic           done;
      logic           last;
   } pixel_type;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lrs_req_if req_bus ();
   lrs_rsp_if rsp_bus ();
   lrs_csr_if csr_bus ();

   line_rasterizer_stepper u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor state, mirrors the walker inside the block.
   logic [CB-1:0] pw_x, pw_y, pt_x, pt_y, po_x, po_y, pa_dx, pa_dy;
   logic [1:0]    p_signs;
   int            p_err;
   longint        p_len2;
   bit            p_active;
   bit            p_smooth;

   pixel_type pending_pixels[$];
   int     mismatches;
   int     idle_cycles;
   bit     timed_out;
   bit     sweep_busy;     // random stall pattern on/off for the response side

   // floor(sqrt(num/den) * 2^FB); returns 0 if fragment is dropped.
   function automatic bit calc_ratio(input longint num, input longint den,
                                     output longint q);
      longint r, v, c;
      q = 0;
      if (den == 0) return (num == 0);
      if (num > den) return 0;
      v = (num == den) ? 1 : 0;
      r = (num == den) ? 0 : num;
      for (int i = 0; i < 2 * FB; i++) begin
         r = r << 1;
         v = v << 1;
         if (r >= den) begin
            r = r - den;
            v = v | 1;
         end
      end
      for (int b = FB; b >= 0; b--) begin
         c = q | (longint'(1) << b);
         if (c * c <= v) q = c;
      end
      return 1;
   endfunction

   function automatic longint dist_abs(input logic [CB-1:0] a, input logic [CB-1:0] b);
      return (a >= b) ? longint'(a - b) : longint'(b - a);
   endfunction

   // Queue a fragment if its fraction (and coverage, when given) fits 1.0.
   task automatic add_pixel(input logic [CB-1:0] x, input logic [CB-1:0] y,
                            input bit use_cov, input longint dsq, ref pixel_type frags[$]);
      longint cov, frac, fx, fy;
      pixel_type p;
      cov = 0;
      if (use_cov && !calc_ratio(dsq, p_len2, cov)) return;
      fx = dist_abs(pw_x, po_x);
      fy = dist_abs(pw_y, po_y);
      if (!calc_ratio(fx * fx + fy * fy, p_len2, frac)) return;
      p.x = x; p.y = y; p.cov = cov[Q_W-1:0]; p.frac = frac[Q_W-1:0];
      p.done = 0; p.last = 0;
      frags.push_back(p);
   endtask

   task automatic predict_item(input logic op, input logic [CB-1:0] sx0,
                               input logic [CB-1:0] sy0, input logic [CB-1:0] ex,
                               input logic [CB-1:0] ey);
      pixel_type frags[$];
      bit done;
      longint dx, dy, err, e2, m, d;
      logic [CB-1:0] stx, sty, xs;
      if (op == lrs_pkg::OP_START) begin
         po_x = sx0; pw_x = sx0; po_y = sy0; pw_y = sy0; pt_x = ex; pt_y = ey;
         pa_dx = CB'(dist_abs(sx0, ex));
         pa_dy = CB'(dist_abs(sy0, ey));
         p_signs = {sy0 >= ey, sx0 >= ex};
         p_err = int'(pa_dx) - int'(pa_dy);
         p_len2 = longint'(pa_dx) * pa_dx + longint'(pa_dy) * pa_dy;
         p_active = 1;
         return;
      end
      if (!p_active) return;
      if (p_len2 == 0) begin
         add_pixel(pw_x, pw_y, 0, 0, frags);
         done = 1;
      end else begin
         dx = pa_dx; dy = pa_dy; err = p_err;
         stx = p_signs[0] ? '1 : CB'(1);
         sty = p_signs[1] ? '1 : CB'(1);
         if (p_smooth) begin
            d = err - dx + dy;
            if (d < 0) d = -d;
            add_pixel(pw_x, pw_y, 1, d * d, frags);
         end else begin
            add_pixel(pw_x, pw_y, 0, 0, frags);
         end
         done = (pw_x == pt_x) && (pw_y == pt_y);
         if (!done) begin
            e2 = 2 * err;
            xs = pw_x;
            if (p_smooth) begin
               // neighbours use the error from before this step
               if (e2 >= -dx) begin
                  m = p_err + dy;
                  if (m >= 0 && m * m < p_len2) add_pixel(xs, pw_y + sty, 1, m * m, frags);
                  err -= dy;
                  pw_x = pw_x + stx;
               end
               if (e2 <= dy) begin
                  m = dx - p_err;
                  if (m >= 0 && m * m < p_len2) add_pixel(xs + stx, pw_y, 1, m * m, frags);
                  err += dx;
                  pw_y = pw_y + sty;
               end
            end else begin
               if (e2 >= -dy) begin
                  err -= dy;
                  pw_x = pw_x + stx;
               end
               if (e2 <= dx) begin
                  err += dx;
                  pw_y = pw_y + sty;
               end
            end
            p_err = int'(err);
         end
      end
      if (done) p_active = 0;
      foreach (frags[k]) begin
         frags[k].done = done;
         frags[k].last = (k == frags.size() - 1);
         pending_pixels.push_back(frags[k]);
      end
   endtask

   // Send one item; bursts of random length, random gaps between them.
   // valid stays up after a transfer until the next item, a gap or a drain.
   int burst_left;
   task automatic send_item(input logic op, input logic [CB-1:0] sx0,
                            input logic [CB-1:0] sy0, input logic [CB-1:0] ex,
                            input logic [CB-1:0] ey);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.start_x   <= sx0;
      req_bus.start_y   <= sy0;
      req_bus.end_x     <= ex;
      req_bus.end_y     <= ey;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_item(op, sx0, sy0, ex, ey);
   endtask

   // Wait for the block to drain before touching the register.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0 && !timed_out) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_smooth(input bit val);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      p_smooth = val;
   endtask

   task automatic walk_line(input logic [CB-1:0] sx0, input logic [CB-1:0] sy0,
                            input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                            input int steps);
      send_item(lrs_pkg::OP_START, sx0, sy0, ex, ey);
      repeat (steps) send_item(lrs_pkg::OP_STEP, CB'($urandom), CB'($urandom),
                               CB'($urandom), CB'($urandom));
   endtask

   // Corners, zero length, step with no line loaded, lines in three directions.
   task automatic test_directed_plain();
      send_item(lrs_pkg::OP_STEP, '1, '1, '1, '1);
      walk_line(12'd5, 12'd5, 12'd5, 12'd5, 2);
      walk_line(12'd0, 12'd0, 12'd4, 12'd2, 6);
      walk_line(12'd4095, 12'd4095, 12'd4092, 12'd4090, 7);
      walk_line(12'd0, 12'd4095, 12'd4095, 12'd0, 3);
   endtask

   task automatic test_directed_smooth();
      write_smooth(1);
      walk_line(12'd10, 12'd20, 12'd7, 12'd26, 7);
      walk_line(12'd0, 12'd0, 12'd3, 12'd3, 4);
      walk_line(12'd9, 12'd9, 12'd9, 12'd9, 1);
      walk_line(12'd4095, 12'd0, 12'd0, 12'd4095, 2);
   endtask

   // Mostly short lines walked to the end, some noise and cut-off lines.
   task automatic test_random(input int count);
      logic [CB-1:0] a, b, c, d;
      int sent, len, next_mode;
      bit held;
      sent = 0;
      next_mode = 80;
      held = 0;
      while (sent < count) begin
         if (sent >= next_mode) begin
            write_smooth($urandom_range(0, 1));
            next_mode += 80;
         end
         if (!held && sent >= count / 2) begin
            drain();   // sender holds off until all results are in
            held = 1;
         end
         a = CB'($urandom); b = CB'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            c = CB'($urandom); d = CB'($urandom);
         end else begin
            c = a + CB'($urandom_range(0, 16)) - CB'(8);
            d = b + CB'($urandom_range(0, 16)) - CB'(8);
         end
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(4, 18);
         walk_line(a, b, c, d, len);
         sent += len + 1;
      end
   endtask

   // Response checker and stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected fragment x=%0d y=%0d",
                                              rsp_bus.pixel_x, rsp_bus.pixel_y);
            end else begin
               pixel_type e;
               e = pending_pixels.pop_front();
               if (rsp_bus.pixel_x !== e.x || rsp_bus.pixel_y !== e.y ||
                   rsp_bus.coverage !== e.cov || rsp_bus.along_fraction !== e.frac ||
                   rsp_bus.line_done !== e.done || rsp_bus.last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp x=%0d y=%0d cov=%0d fr=%0d d=%0b l=%0b",
                               " got x=%0d y=%0d cov=%0d fr=%0d d=%0b l=%0b"},
                              e.x, e.y, e.cov, e.frac, e.done, e.last, rsp_bus.pixel_x,
                              rsp_bus.pixel_y, rsp_bus.coverage, rsp_bus.along_fraction,
                              rsp_bus.line_done, rsp_bus.last);
               end
            end
         end
         if ($urandom_range(0, 63) == 0) sweep_busy <= ~sweep_busy;
         rsp_bus.ready <= sweep_busy ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 0; req_bus.operation = lrs_pkg::OP_START;
      req_bus.start_x = 0; req_bus.start_y = 0; req_bus.end_x = 0; req_bus.end_y = 0;
      csr_bus.valid = 0; csr_bus.data = 0;
      mismatches = 0; idle_cycles = 0; timed_out = 0; sweep_busy = 0;
      burst_left = 0; p_active = 0; p_smooth = 0; p_len2 = 0; p_err = 0;
      pw_x = 0; pw_y = 0; pt_x = 0; pt_y = 0; po_x = 0; po_y = 0;
      pa_dx = 0; pa_dy = 0; p_signs = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_plain();
      test_directed_smooth();
      write_smooth(0);
      test_random(360);
      write_smooth(1);
      drain();
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
